// ===== hw/rtl/dqsdw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqsdw_pkg
// shared types and constants of the dqs delay window trainer
// ----------------------------------------------------------------------------
package dqsdw_pkg;

   localparam int unsigned LANES = 4;

   // lane in training, finished code after the last lane
   localparam logic [2:0] PHASE_DONE = 3'd4;

   // register indexes of the csr port
   localparam logic [2:0] CSR_DELAY_STEP   = 3'd0;
   localparam logic [2:0] CSR_DELAY_LIMIT  = 3'd1;
   localparam logic [2:0] CSR_INITIAL_DLL  = 3'd2;
   localparam logic [2:0] CSR_PATTERN_0    = 3'd3;
   localparam logic [2:0] CSR_PATTERN_1    = 3'd4;
   localparam logic [2:0] CSR_PATTERN_2    = 3'd5;
   localparam logic [2:0] CSR_PATTERN_3    = 3'd6;

   // register reset values
   localparam logic [7:0]  RST_DELAY_STEP  = 8'h02;
   localparam logic [7:0]  RST_DELAY_LIMIT = 8'h80;
   localparam logic [31:0] RST_INITIAL_DLL = 32'h0;
   localparam logic [31:0] RST_PATTERN_01  = 32'hffff0000;
   localparam logic [31:0] RST_PATTERN_23  = 32'h5a5aa5a5;

   // request codes
   localparam logic REQ_START    = 1'b0;
   localparam logic REQ_READBACK = 1'b1;

   // byte of the dll word that each lane occupies: wr0, rd0, wr1, rd1
   localparam logic [1:0] LANE_BYTE [LANES] = '{2'd1, 2'd0, 2'd3, 2'd2};

   typedef struct packed {
      logic [7:0]       delay_step;
      logic [7:0]       delay_limit;
      logic [31:0]      initial_dll_word;
      logic [3:0][31:0] pattern;
   } cfg_type;

   typedef struct packed {
      logic [31:0] dll_word;
      logic [2:0]  phase;
      logic        done_res;
      logic        no_window;
      logic        step_failed;
   } result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/dqsdw_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqsdw_csr
// configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
module dqsdw_csr
   import dqsdw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DELAY_STEP:  cfg_in.delay_step       = csr_write_data[7:0];
            CSR_DELAY_LIMIT: cfg_in.delay_limit      = csr_write_data[7:0];
            CSR_INITIAL_DLL: cfg_in.initial_dll_word = csr_write_data;
            CSR_PATTERN_0:   cfg_in.pattern[0]       = csr_write_data;
            CSR_PATTERN_1:   cfg_in.pattern[1]       = csr_write_data;
            CSR_PATTERN_2:   cfg_in.pattern[2]       = csr_write_data;
            CSR_PATTERN_3:   cfg_in.pattern[3]       = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_step       <= RST_DELAY_STEP;
         cfg_ff.delay_limit      <= RST_DELAY_LIMIT;
         cfg_ff.initial_dll_word <= RST_INITIAL_DLL;
         cfg_ff.pattern[0]       <= RST_PATTERN_01;
         cfg_ff.pattern[1]       <= RST_PATTERN_01;
         cfg_ff.pattern[2]       <= RST_PATTERN_23;
         cfg_ff.pattern[3]       <= RST_PATTERN_23;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dqsdw_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqsdw_core
// training state and the single-pass update for one accepted request
// ----------------------------------------------------------------------------
module dqsdw_core
   import dqsdw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        accept,
   input  wire logic        req_type,
   input  wire logic [31:0] req_read_data,
   output logic             res_valid,
   output result_type       res
);

   logic [2:0] phase_ff,     phase_in;
   logic [7:0] sweep_ff,     sweep_in;
   logic [1:0] index_ff,     index_in;
   logic       mismatch_ff,  mismatch_in;
   logic       low_found_ff, low_found_in;
   logic [7:0] low_ff,       low_in;
   logic       aborted_ff,   aborted_in;
   logic [7:0] centre_ff [LANES];
   logic [7:0] centre_in [LANES];

   always_comb begin
      logic       seen;
      logic       close_en;
      logic [7:0] close_high;
      logic [8:0] next_sum;
      logic [8:0] centre_sum;
      logic [31:0] word;

      phase_in     = phase_ff;
      sweep_in     = sweep_ff;
      index_in     = index_ff;
      mismatch_in  = mismatch_ff;
      low_found_in = low_found_ff;
      low_in       = low_ff;
      aborted_in   = aborted_ff;
      centre_in    = centre_ff;
      res_valid    = 1'b0;
      seen         = 1'b0;
      close_en     = 1'b0;
      close_high   = sweep_ff;
      next_sum     = {1'b0, sweep_ff} + {1'b0, cfg.delay_step};
      centre_sum   = '0;
      word         = cfg.initial_dll_word;
      res.step_failed = 1'b0;

      if (accept) begin
         if (req_type == REQ_START) begin
            phase_in     = '0;
            sweep_in     = '0;
            index_in     = '0;
            mismatch_in  = 1'b0;
            low_found_in = 1'b0;
            low_in       = '0;
            aborted_in   = 1'b0;
            for (int p = 0; p < LANES; p++) centre_in[p] = '0;
            res_valid    = 1'b1;
         end else if (!aborted_ff && !phase_ff[2]) begin
            seen = mismatch_ff | (req_read_data != cfg.pattern[index_ff]);
            if (index_ff != 2'd3) begin
               index_in    = index_ff + 2'd1;
               mismatch_in = seen;
            end else begin
               // step judged
               index_in        = '0;
               mismatch_in     = 1'b0;
               res_valid       = 1'b1;
               res.step_failed = seen;
               if (low_found_ff && (seen || sweep_ff > cfg.delay_limit)) begin
                  close_en   = 1'b1;
                  close_high = sweep_ff - cfg.delay_step;
               end else begin
                  if (!low_found_ff && !seen) begin
                     low_in       = sweep_ff;
                     low_found_in = 1'b1;
                  end
                  if (next_sum[8]) begin
                     // sweep ran off the top of the delay range
                     if (low_found_in) close_en = 1'b1;
                     else              aborted_in = 1'b1;
                  end else begin
                     sweep_in = next_sum[7:0];
                  end
               end
            end
         end
      end

      if (close_en) begin
         centre_sum = {1'b0, low_in} + {1'b0, close_high};
         centre_in[phase_ff[1:0]] = centre_sum[8:1];
         phase_in     = phase_ff + 3'd1;
         sweep_in     = '0;
         low_found_in = 1'b0;
         low_in       = '0;
      end

      // pack the word for the next step from the updated state
      for (int p = 0; p < LANES; p++) begin
         if (3'(p) < phase_in) begin
            word[LANE_BYTE[p]*8 +: 8] = centre_in[p];
         end else if (3'(p) == phase_in) begin
            word[LANE_BYTE[p]*8 +: 8] = sweep_in;
         end
      end

      res.dll_word  = word;
      res.phase     = phase_in;
      res.done_res  = (phase_in == PHASE_DONE);
      res.no_window = aborted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         sweep_ff     <= '0;
         index_ff     <= '0;
         mismatch_ff  <= 1'b0;
         low_found_ff <= 1'b0;
         low_ff       <= '0;
         aborted_ff   <= 1'b0;
         for (int p = 0; p < LANES; p++) centre_ff[p] <= '0;
      end else begin
         phase_ff     <= phase_in;
         sweep_ff     <= sweep_in;
         index_ff     <= index_in;
         mismatch_ff  <= mismatch_in;
         low_found_ff <= low_found_in;
         low_ff       <= low_in;
         aborted_ff   <= aborted_in;
         centre_ff    <= centre_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/dqs_delay_window_trainer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqs_delay_window_trainer_top
// dqs delay eye-centre training over two byte lanes, write and read delays
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  --------------------------------------------
//  req      req_valid / req_ready  req_type, req_read_data
//  rsp      rsp_valid / rsp_ready  rsp_dll_word, rsp_phase, rsp_done_res,
//                                  rsp_no_window, rsp_step_failed
//  csr      csr_write_enable       csr_index, csr_write_data
//
//  one request is accepted per cycle; its response, if any, is valid the
//  cycle after acceptance from the response register
//  the rate is set by the single response register: req_ready stays high
//  while that register is empty or being drained in the same cycle
//  reset is synchronous and active high, clears the training state and the
//  response valid, and loads the register reset values
//  a stalled response holds; requests stall only behind it
//
module dqs_delay_window_trainer_top
   import dqsdw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // requests
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [31:0] req_read_data,
   // responses
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_dll_word,
   output logic [2:0]       rsp_phase,
   output logic             rsp_done_res,
   output logic             rsp_no_window,
   output logic             rsp_step_failed,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   cfg_type    cfg;
   result_type res;
   logic       res_valid;
   logic       accept;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   dqsdw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // request can go when the response slot is free or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   dqsdw_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .accept        (accept),
      .req_type      (req_type),
      .req_read_data (req_read_data),
      .res_valid     (res_valid),
      .res           (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      // readbacks inside a step produce nothing
      if (res_valid) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only loads with a new response
   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dll_word    = rsp_ff.dll_word;
   assign rsp_phase       = rsp_ff.phase;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_no_window   = rsp_ff.no_window;
   assign rsp_step_failed = rsp_ff.step_failed;

   // a start request always answers next cycle at lane zero with no flags
   a_start_response: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_START) |=>
         (rsp_valid && rsp_phase == 3'd0 && !rsp_no_window && !rsp_done_res
          && !rsp_step_failed))
      else $error("start request without clean lane zero response");

   // a finished run and an aborted run exclude each other
   a_done_or_abort: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done_res && rsp_no_window))
      else $error("response both done and without window");

   // done flag tracks the finished phase and phase never passes it
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_done_res == (rsp_phase == PHASE_DONE))
                     && rsp_phase <= PHASE_DONE))
      else $error("done flag and phase disagree");

   // a response that is not taken is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !res_valid)
      else $error("new response while the previous one is still held");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dqs delay window trainer: a request-level copy
// of the training state predicts every response, requests are sent in
// random bursts against a stalling receiver, and each response is checked
// field by field in order
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dqsdw_pkg::*;

   // no handshake of any kind for this many cycles means the run is stuck
   localparam int WATCHDOG_LIMIT = 2000;
   // random training stops once this many requests have gone in
   localparam int REQUEST_TARGET = 560;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_type         = REQ_START;
   logic [31:0] req_read_data    = 32'h0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [31:0] rsp_dll_word;
   logic [2:0]  rsp_phase;
   logic        rsp_done_res;
   logic        rsp_no_window;
   logic        rsp_step_failed;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index        = CSR_DELAY_STEP;
   logic [31:0] csr_write_data   = 32'h0;

   dqs_delay_window_trainer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_read_data    (req_read_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dll_word     (rsp_dll_word),
      .rsp_phase        (rsp_phase),
      .rsp_done_res     (rsp_done_res),
      .rsp_no_window    (rsp_no_window),
      .rsp_step_failed  (rsp_step_failed),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // register copy, as the block holds it after reset
   // ---------------------------------------------------------------------
   logic [7:0]  cfg_step    = RST_DELAY_STEP;
   logic [7:0]  cfg_limit   = RST_DELAY_LIMIT;
   logic [31:0] cfg_dll     = RST_INITIAL_DLL;
   logic [31:0] cfg_pattern [4] =
      '{RST_PATTERN_01, RST_PATTERN_01, RST_PATTERN_23, RST_PATTERN_23};

   // ---------------------------------------------------------------------
   // training state copy; reset state equals the freshly started state
   // ---------------------------------------------------------------------
   logic [2:0]  trn_phase     = 3'd0;
   logic [7:0]  trn_delay     = 8'h00;
   logic [1:0]  trn_word_idx  = 2'd0;
   logic        trn_mismatch  = 1'b0;
   logic        trn_low_found = 1'b0;
   logic [7:0]  trn_low       = 8'h00;
   logic [7:0]  trn_centre [4] = '{default: 8'h00};
   logic        trn_aborted   = 1'b0;

   result_type  expected_responses [$];

   int mismatch_count = 0;
   int requests_sent  = 0;
   int burst_left     = 0;
   int idle_cycles    = 0;
   bit steady         = 1'b0;   // sender without gaps
   int stall_mode     = 0;      // receiver behavior, see below

   // dll word as the block presents it: trained lanes give their centre,
   // the lane in training its swept delay, the rest come from the register
   function automatic logic [31:0] packed_dll_word();
      logic [31:0] word;
      logic [7:0]  lane_byte;
      int          shift;
      word = cfg_dll;
      for (int p = 0; p < LANES; p++) begin
         if (p < trn_phase)
            lane_byte = trn_centre[p];
         else if (p == trn_phase)
            lane_byte = trn_delay;
         else
            continue;
         // byte order wr0 -> byte1, rd0 -> byte0, wr1 -> byte3, rd1 -> byte2
         shift = (p == 0) ? 8 : (p == 1) ? 0 : (p == 2) ? 24 : 16;
         word[shift +: 8] = lane_byte;
      end
      return word;
   endfunction

   function automatic void queue_response(input logic failed);
      result_type r;
      r.dll_word    = packed_dll_word();
      r.phase       = trn_phase;
      r.done_res    = (trn_phase >= PHASE_DONE);
      r.no_window   = trn_aborted;
      r.step_failed = failed;
      expected_responses.push_back(r);
   endfunction

   // store the centre of the open window and move to the next lane
   function automatic void close_lane(input logic [7:0] high);
      logic [8:0] sum;
      sum = {1'b0, trn_low} + {1'b0, high};
      if (trn_phase < PHASE_DONE)
         trn_centre[trn_phase[1:0]] = sum[8:1];
      trn_phase     = trn_phase + 3'd1;
      trn_delay     = 8'h00;
      trn_low_found = 1'b0;
      trn_low       = 8'h00;
   endfunction

   // advance the training copy by one accepted request
   function automatic void train_on_request(input logic kind, input logic [31:0] data);
      logic       failed;
      logic [8:0] next_delay;
      if (kind == REQ_START) begin
         trn_phase     = 3'd0;
         trn_delay     = 8'h00;
         trn_word_idx  = 2'd0;
         trn_mismatch  = 1'b0;
         trn_low_found = 1'b0;
         trn_low       = 8'h00;
         trn_centre    = '{default: 8'h00};
         trn_aborted   = 1'b0;
         queue_response(1'b0);
         return;
      end
      // finished or aborted: readbacks are dropped until the next start
      if (trn_aborted || trn_phase >= PHASE_DONE)
         return;
      if (data != cfg_pattern[trn_word_idx])
         trn_mismatch = 1'b1;
      if (trn_word_idx != 2'd3) begin
         trn_word_idx = trn_word_idx + 2'd1;
         return;
      end
      // fourth readback: judge the step
      trn_word_idx = 2'd0;
      failed       = trn_mismatch;
      trn_mismatch = 1'b0;
      if (!trn_low_found) begin
         if (!failed) begin
            trn_low       = trn_delay;
            trn_low_found = 1'b1;
         end
      end else if (failed || trn_delay > cfg_limit) begin
         close_lane(trn_delay - cfg_step);
         queue_response(failed);
         return;
      end
      next_delay = {1'b0, trn_delay} + {1'b0, cfg_step};
      if (next_delay > 9'h0ff) begin
         // sweep ran off the top: close an open window here, else give up
         if (trn_low_found)
            close_lane(trn_delay);
         else
            trn_aborted = 1'b1;
      end else begin
         trn_delay = next_delay[7:0];
      end
      queue_response(failed);
   endfunction

   // ---------------------------------------------------------------------
   // response check, in order, against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response, dll_word %h phase %0d", $time,
                     rsp_dll_word, rsp_phase);
            mismatch_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_dll_word !== want.dll_word) begin
               $display("%0t: dll_word expected %h actual %h", $time,
                        want.dll_word, rsp_dll_word);
               mismatch_count++;
            end
            if (rsp_phase !== want.phase) begin
               $display("%0t: phase expected %0d actual %0d", $time,
                        want.phase, rsp_phase);
               mismatch_count++;
            end
            if (rsp_done_res !== want.done_res) begin
               $display("%0t: done_res expected %b actual %b", $time,
                        want.done_res, rsp_done_res);
               mismatch_count++;
            end
            if (rsp_no_window !== want.no_window) begin
               $display("%0t: no_window expected %b actual %b", $time,
                        want.no_window, rsp_no_window);
               mismatch_count++;
            end
            if (rsp_step_failed !== want.step_failed) begin
               $display("%0t: step_failed expected %b actual %b", $time,
                        want.step_failed, rsp_step_failed);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: 0 always ready, 1 light random stalls, 2 fixed pattern of
   // stalls, 3 heavy random stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_rsp_ready
      int unsigned ready_cycle;
      ready_cycle++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= (ready_cycle % 7 != 3) && (ready_cycle % 11 > 2);
         default: rsp_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   // watchdog: ends the run when nothing moves for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // one request; the sender runs in bursts, with random gaps between them unless steady
   task automatic send_request(input logic kind, input logic [31:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_read_data <= data;
      do @(posedge clock); while (!req_ready);
      train_on_request(kind, data);
      burst_left--;
      requests_sent++;
   endtask

   // stop sending until every predicted response has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_responses.size() != 0);
   endtask

   // one register write; enable is left high so writes can run back to back
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         CSR_DELAY_STEP:  cfg_step       = value[7:0];
         CSR_DELAY_LIMIT: cfg_limit      = value[7:0];
         CSR_INITIAL_DLL: cfg_dll        = value;
         CSR_PATTERN_0:   cfg_pattern[0] = value;
         CSR_PATTERN_1:   cfg_pattern[1] = value;
         CSR_PATTERN_2:   cfg_pattern[2] = value;
         CSR_PATTERN_3:   cfg_pattern[3] = value;
         default: ;
      endcase
   endtask

   // new settings, written only once the block has gone quiet
   task automatic program_trainer(input logic [7:0] step, input logic [7:0] limit,
                                  input logic [31:0] dll, input logic [3:0][31:0] pats);
      hold_until_drained();
      // a readback with no response may still be in flight
      repeat (2) @(posedge clock);
      write_reg(CSR_DELAY_STEP, {24'h0, step});
      write_reg(CSR_DELAY_LIMIT, {24'h0, limit});
      write_reg(CSR_INITIAL_DLL, dll);
      write_reg(CSR_PATTERN_0, pats[0]);
      write_reg(CSR_PATTERN_1, pats[1]);
      write_reg(CSR_PATTERN_2, pats[2]);
      write_reg(CSR_PATTERN_3, pats[3]);
      csr_write_enable <= 1'b0;
   endtask

   // readbacks up to the end of the current step; bad_at < 0 sends a
   // clean step, otherwise the word at that pattern slot and, at random, others are corrupted
   task automatic send_step(input int bad_at);
      logic [31:0] word;
      logic [31:0] mask;
      do begin
         word = cfg_pattern[trn_word_idx];
         if (bad_at >= 0 && (trn_word_idx == bad_at || $urandom_range(0, 7) == 0)) begin
            mask = $urandom();
            if (mask == 32'h0)
               mask = 32'h1 << $urandom_range(0, 31);
            word = word ^ mask;
            if ($urandom_range(0, 4) == 0)
               word = (cfg_pattern[trn_word_idx] == 32'h0) ? ~32'h0 : 32'h0;
         end
         send_request(REQ_READBACK, word);
      end while (trn_word_idx != 2'd0);
   endtask

   // one full training: each lane gets an eye of passing delays starting at most
   // two steps in, with occasional glitches, stray readbacks and restarts
   task automatic train_lanes(input bit pause_midway);
      int  eye_lo [4];
      int  eye_hi [4];
      int  s;
      int  steps;
      bit  pass;
      s = (cfg_step == 8'h00) ? 1 : cfg_step;
      for (int l = 0; l < LANES; l++) begin
         eye_lo[l] = $urandom_range(0, 2) * s;
         eye_hi[l] = eye_lo[l] + $urandom_range(0, 4) * s + $urandom_range(0, s - 1);
         // big steps abort quickly, so let some lanes have no eye at all
         if (s >= 48 && $urandom_range(0, 5) == 0) begin
            eye_lo[l] = 1000;
            eye_hi[l] = 0;
         end
      end
      send_request(REQ_START, $urandom());
      steps = 0;
      while (trn_phase < PHASE_DONE && !trn_aborted && steps < 80) begin
         pass = (trn_delay >= eye_lo[trn_phase]) && (trn_delay <= eye_hi[trn_phase]);
         if ($urandom_range(0, 15) == 0)
            pass = !pass;
         case ($urandom_range(0, 23))
            0: repeat ($urandom_range(1, 3)) send_request(REQ_READBACK, $urandom());
            1: send_request(REQ_START, $urandom());
            default: ;
         endcase
         send_step(pass ? -1 : $urandom_range(0, 3));
         steps++;
         if (pause_midway && steps == 3)
            hold_until_drained();
      end
      // readbacks after the end are dropped by the block
      if ($urandom_range(0, 1))
         repeat ($urandom_range(1, 2)) send_request(REQ_READBACK, $urandom());
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // readbacks straight out of reset train like after a start
   task automatic test_early_readbacks();
      stall_mode = 0;
      steady     = 1'b1;
      send_request(REQ_READBACK, RST_PATTERN_01);
      send_request(REQ_READBACK, RST_PATTERN_01);
      send_request(REQ_READBACK, RST_PATTERN_23);
      send_request(REQ_READBACK, RST_PATTERN_23);
   endtask

   // start, a failing step, a passing step, then a failure closing lane 0
   task automatic test_start_and_steps();
      stall_mode = 1;
      steady     = 1'b0;
      send_request(REQ_START, 32'hffff_ffff);
      send_request(REQ_READBACK, RST_PATTERN_01);
      send_request(REQ_READBACK, RST_PATTERN_01);
      send_request(REQ_READBACK, RST_PATTERN_23);
      send_request(REQ_READBACK, 32'h0);
      send_request(REQ_READBACK, RST_PATTERN_01);
      send_request(REQ_READBACK, RST_PATTERN_01);
      send_request(REQ_READBACK, RST_PATTERN_23);
      send_request(REQ_READBACK, RST_PATTERN_23);
      send_request(REQ_READBACK, 32'hffff_ffff);
      send_request(REQ_READBACK, RST_PATTERN_01);
      send_request(REQ_READBACK, RST_PATTERN_23);
      send_request(REQ_READBACK, RST_PATTERN_23);
   endtask

   // widest step with no passing delay: sweep runs off the top and aborts
   task automatic test_abort_no_window();
      stall_mode = 2;
      program_trainer(8'hff, 8'hff, $urandom(),
                      {RST_PATTERN_23, RST_PATTERN_23, RST_PATTERN_01, RST_PATTERN_01});
      send_request(REQ_START, $urandom());
      send_step(0);
      send_step(3);
      // aborted: this one is dropped
      send_request(REQ_READBACK, $urandom());
   endtask

   // register extremes: smallest and largest step, limit at both ends,
   // all-zero and all-one words
   task automatic test_config_extremes();
      stall_mode = 3;
      program_trainer(8'h01, 8'h00, 32'hffff_ffff, {4{32'h0}});
      train_lanes(1'b0);
      stall_mode = 2;
      program_trainer(8'hff, 8'h00, 32'h0, {4{32'hffff_ffff}});
      train_lanes(1'b0);
      stall_mode = 0;
      program_trainer(8'h01, 8'hff, $urandom(), {$urandom(), $urandom(), $urandom(), $urandom()});
      train_lanes(1'b0);
      // big step with an eye reaching the top closes at the last delay
      stall_mode = 1;
      program_trainer(8'd200, 8'hff, $urandom(), {$urandom(), $urandom(), $urandom(), $urandom()});
      train_lanes(1'b0);
   endtask

   // random settings, each followed by one or two trainings
   task automatic test_random_training();
      logic [7:0]       step;
      logic [7:0]       limit;
      logic [3:0][31:0] pats;
      bit               paused;
      paused = 1'b0;
      while (requests_sent < REQUEST_TARGET) begin
         case ($urandom_range(0, 7))
            0:       step = 8'h01;
            1:       step = 8'hff;
            default: step = 8'($urandom_range(2, 80));
         endcase
         case ($urandom_range(0, 7))
            0:       limit = 8'h00;
            1:       limit = 8'hff;
            default: limit = 8'($urandom_range(0, 255));
         endcase
         pats = {$urandom(), $urandom(), $urandom(), $urandom()};
         if ($urandom_range(0, 3) == 0)
            pats = {4{pats[0]}};
         program_trainer(step, limit, $urandom(), pats);
         stall_mode = $urandom_range(0, 3);
         steady     = ($urandom_range(0, 3) == 0);
         // the first training stops once midway until all responses are in
         train_lanes(!paused);
         paused = 1'b1;
         if ($urandom_range(0, 1))
            train_lanes(1'b0);
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_early_readbacks();
      test_start_and_steps();
      test_abort_no_window();
      test_config_extremes();
      test_random_training();
      hold_until_drained();
      // catch any stray response after the last expected one
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
